>>> sv/tli_pkg.sv
// Shared constants, codes and types of the table linear interpolator.
`default_nettype none

package tli_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int LEN_W       = IDX_W + 1;

	// Item field widths
	localparam int DATA_W      = 32;
	localparam int SEG_W       = 7;
	localparam int ENTRY_IDX_W = 6;

	// Arithmetic widths
	localparam int MAG_W  = DATA_W + 1;        // magnitude of a difference
	localparam int PROD_W = 2 * MAG_W;         // full product
	localparam int QUO_W  = 41;                // quotient, capped at 2^40
	localparam int ADD_W  = 44;                // shared adder
	localparam int CNT_W  = $clog2(PROD_W);

	localparam logic [QUO_W:0] QUOT_CAP = (QUO_W + 1)'(1) << (QUO_W - 1);

	// Configuration port
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

	typedef enum logic {
		REG_TABLE_LENGTH = 1'b0,
		REG_UNUSED       = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		OUT_INTERP   = 2'd0,
		OUT_EXACT    = 2'd1,
		OUT_CLAMP_LO = 2'd2,
		OUT_BEYOND   = 2'd3
	} outcome_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_RD1,
		S_RD0,
		S_DX,
		S_DV,
		S_DQ,
		S_AX,
		S_AV,
		S_AQ,
		S_MUL,
		S_DIV,
		S_SUM,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

>>> sv/tli_if.sv
// Valid/ready channels of the table linear interpolator: input items and result items.
`default_nettype none

interface tli_in_if;
	logic                                 valid;
	logic                                 ready;
	tli_pkg::command_t                    command;
	logic        [tli_pkg::ENTRY_IDX_W-1:0] entry_index;
	logic signed [tli_pkg::DATA_W-1:0]    entry_x;
	logic signed [tli_pkg::DATA_W-1:0]    entry_value;
	logic signed [tli_pkg::DATA_W-1:0]    query_x;

	modport source (output valid, command, entry_index, entry_x, entry_value, query_x,
		input ready);
	modport sink (input valid, command, entry_index, entry_x, entry_value, query_x,
		output ready);
endinterface

interface tli_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [tli_pkg::DATA_W-1:0] interp_value;
	logic        [tli_pkg::SEG_W-1:0]  segment_index;
	tli_pkg::outcome_t                 outcome;

	modport source (output valid, interp_value, segment_index, outcome, input ready);
	modport sink (input valid, interp_value, segment_index, outcome, output ready);
endinterface

`default_nettype wire

>>> sv/table_linear_interpolator.sv
// Top level of the table linear interpolator: table memory, search and interpolation sequencer.
//
// The block holds up to 64 breakpoint/value pairs in signed Q16.16. A write item
// (command 0) stores one pair and gives no result. A query item (command 1) gives
// one result: a binary search over the first table_length entries finds the first
// breakpoint not below the query; the answer is the last value when there is none,
// entry zero's value when it is entry zero, the entry's own value on an exact match,
// and otherwise v0 + (dv * dq) / dx, product formed exactly, quotient truncated
// toward zero and capped at 2^40, sum saturated to 32 bits. Every arithmetic step of
// a query runs through one shared 44-bit add/subtract unit under a sequencer: each
// search step reads memory and then compares, for up to seven steps; then the entry
// found is read, its lower neighbour is fetched, differences and magnitudes are
// formed, a shift-add multiply and a restoring divide run, and the final sum is made.
// The block takes no new item until the result has left. table_length is written
// through the APB port at byte address 0 (7 bits, reset 1); zero acts as 1 and values
// above 64 act as 64. Entries must be written before a query reads them.
`default_nettype none

module table_linear_interpolator import tli_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	tli_in_if.sink                  in_chan,
	tli_out_if.source               out_chan
);

	// Sequencer
	state_t state_q, state_d;

	// Configuration
	logic [LEN_W-1:0] len_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	// Table memory, registered read port
	logic [DATA_W-1:0] bp_mem  [TABLE_DEPTH];
	logic [DATA_W-1:0] val_mem [TABLE_DEPTH];
	logic [IDX_W-1:0]  rd_addr;
	logic signed [DATA_W-1:0] rd_x_q, rd_v_q;

	// Query context
	logic signed [DATA_W-1:0] xq_q, x1_q, v1_q, x0_q, v0_q;
	logic [LEN_W-1:0] n_q, lo_q, hi_q, n_clamp, mid;
	logic [LEN_W:0]   mid_sum;
	logic [IDX_W-1:0] pick_addr;
	logic             in_acc, search_more;

	// Arithmetic
	logic [MAG_W-1:0]  dx_q, dv_q, dq_q;
	logic              neg_q;
	logic [PROD_W:0]   p_q;
	logic [MAG_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [QUO_W:0]    quo_wide;
	logic [CNT_W-1:0]  cnt_q;
	logic              div_ge;

	// Shared adder
	logic [ADD_W-1:0] add_a, add_b, add_sum;
	logic             add_sub;

	// Result
	logic signed [DATA_W-1:0] res_q;
	outcome_t                 outc_q;

	// ------------------------------------------------------------------
	// APB register: one word, writes complete in the access phase.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_TABLE_LENGTH: prdata = PDATA_W'(len_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_wr && reg_idx == REG_TABLE_LENGTH) begin
			len_q <= pwdata[LEN_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Search helpers
	// ------------------------------------------------------------------
	assign in_acc      = in_chan.valid && in_chan.ready;
	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid         = mid_sum[LEN_W:1];
	assign search_more = lo_q < hi_q;
	// Past the end of the table, read the last entry instead.
	assign pick_addr   = (lo_q >= n_q) ? IDX_W'(n_q - LEN_W'(1)) : lo_q[IDX_W-1:0];

	always_comb begin
		n_clamp = len_q;
		if (len_q == '0) begin
			n_clamp = LEN_W'(1);
		end else if (len_q > LEN_W'(TABLE_DEPTH)) begin
			n_clamp = LEN_W'(TABLE_DEPTH);
		end
	end

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && in_chan.command == CMD_QUERY) state_d = S_SRCH;
			end
			S_SRCH: state_d = search_more ? S_CMP : S_RD1;
			S_CMP:  state_d = S_SRCH;
			S_RD1: begin
				if (lo_q >= n_q || lo_q == '0 || rd_x_q == xq_q) begin
					state_d = S_OUT;
				end else begin
					state_d = S_RD0;
				end
			end
			S_RD0: state_d = S_DX;
			S_DX:  state_d = S_DV;
			S_DV:  state_d = (dx_q == '0) ? S_OUT : S_DQ;
			S_DQ:  state_d = S_AX;
			S_AX:  state_d = S_AV;
			S_AV:  state_d = S_AQ;
			S_AQ:  state_d = S_MUL;
			S_MUL: state_d = (cnt_q == CNT_W'(MAG_W - 1)) ? S_DIV : S_MUL;
			S_DIV: state_d = (cnt_q == CNT_W'(PROD_W - 1)) ? S_SUM : S_DIV;
			S_SUM: state_d = S_OUT;
			S_OUT: begin
				if (out_chan.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Outputs of the sequencer: handshakes, read address, adder operands
	// ------------------------------------------------------------------
	always_comb begin
		in_chan.ready  = 1'b0;
		out_chan.valid = 1'b0;
		rd_addr        = '0;
		add_a          = '0;
		add_b          = '0;
		add_sub        = 1'b0;
		unique case (state_q)
			S_IDLE: in_chan.ready = 1'b1;
			S_SRCH: rd_addr = search_more ? mid[IDX_W-1:0] : pick_addr;
			S_CMP: begin
				// breakpoint - query; negative means breakpoint below query
				add_a   = {{(ADD_W-DATA_W){rd_x_q[DATA_W-1]}}, rd_x_q};
				add_b   = {{(ADD_W-DATA_W){xq_q[DATA_W-1]}}, xq_q};
				add_sub = 1'b1;
			end
			S_RD1: rd_addr = IDX_W'(lo_q - LEN_W'(1));
			S_RD0: ;
			S_DX: begin
				add_a   = {{(ADD_W-DATA_W){x1_q[DATA_W-1]}}, x1_q};
				add_b   = {{(ADD_W-DATA_W){x0_q[DATA_W-1]}}, x0_q};
				add_sub = 1'b1;
			end
			S_DV: begin
				add_a   = {{(ADD_W-DATA_W){v1_q[DATA_W-1]}}, v1_q};
				add_b   = {{(ADD_W-DATA_W){v0_q[DATA_W-1]}}, v0_q};
				add_sub = 1'b1;
			end
			S_DQ: begin
				add_a   = {{(ADD_W-DATA_W){xq_q[DATA_W-1]}}, xq_q};
				add_b   = {{(ADD_W-DATA_W){x0_q[DATA_W-1]}}, x0_q};
				add_sub = 1'b1;
			end
			S_AX: begin
				add_b   = {{(ADD_W-MAG_W){dx_q[MAG_W-1]}}, dx_q};
				add_sub = 1'b1;
			end
			S_AV: begin
				add_b   = {{(ADD_W-MAG_W){dv_q[MAG_W-1]}}, dv_q};
				add_sub = 1'b1;
			end
			S_AQ: begin
				add_b   = {{(ADD_W-MAG_W){dq_q[MAG_W-1]}}, dq_q};
				add_sub = 1'b1;
			end
			S_MUL: begin
				// add multiplicand into the upper half when the low bit is set
				add_a = ADD_W'(p_q[PROD_W:MAG_W]);
				add_b = p_q[0] ? ADD_W'(dv_q) : '0;
			end
			S_DIV: begin
				add_a   = ADD_W'({rem_q, p_q[PROD_W-1]});
				add_b   = ADD_W'(dx_q);
				add_sub = 1'b1;
			end
			S_SUM: begin
				add_a   = {{(ADD_W-DATA_W){v0_q[DATA_W-1]}}, v0_q};
				add_b   = ADD_W'(quo_q);
				add_sub = neg_q;
			end
			S_OUT: out_chan.valid = 1'b1;
			default: ;
		endcase
	end

	assign add_sum  = add_a + (add_sub ? ~add_b : add_b) + ADD_W'(add_sub);
	assign div_ge   = !add_sum[ADD_W-1];
	assign quo_wide = {quo_q, div_ge};

	assign out_chan.interp_value  = res_q;
	assign out_chan.segment_index = SEG_W'(lo_q);
	assign out_chan.outcome       = outc_q;

	// ------------------------------------------------------------------
	// Table memory: one write port, one registered read port
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc && in_chan.command == CMD_WRITE
				&& LEN_W'(in_chan.entry_index) < LEN_W'(TABLE_DEPTH)) begin
			bp_mem[IDX_W'(in_chan.entry_index)]  <= in_chan.entry_x;
			val_mem[IDX_W'(in_chan.entry_index)] <= in_chan.entry_value;
		end
		rd_x_q <= bp_mem[rd_addr];
		rd_v_q <= val_mem[rd_addr];
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && in_chan.command == CMD_QUERY) begin
					xq_q <= in_chan.query_x;
					n_q  <= n_clamp;
					lo_q <= '0;
					hi_q <= n_clamp;
				end
			end
			S_CMP: begin
				// go right past breakpoints below the query, else left
				if (add_sum[ADD_W-1]) begin
					lo_q <= mid + LEN_W'(1);
				end else begin
					hi_q <= mid;
				end
			end
			S_RD1: begin
				x1_q   <= rd_x_q;
				v1_q   <= rd_v_q;
				res_q  <= rd_v_q;
				if (lo_q >= n_q) begin
					outc_q <= OUT_BEYOND;
				end else if (lo_q == '0) begin
					outc_q <= OUT_CLAMP_LO;
				end else begin
					outc_q <= OUT_EXACT;
				end
			end
			S_RD0: begin
				x0_q <= rd_x_q;
				v0_q <= rd_v_q;
			end
			S_DX: dx_q <= add_sum[MAG_W-1:0];
			S_DV: begin
				dv_q <= add_sum[MAG_W-1:0];
				// equal neighbours answer the lower value
				res_q  <= v0_q;
				outc_q <= OUT_INTERP;
			end
			S_DQ: dq_q <= add_sum[MAG_W-1:0];
			S_AX: begin
				neg_q <= dx_q[MAG_W-1] ^ dv_q[MAG_W-1] ^ dq_q[MAG_W-1];
				if (dx_q[MAG_W-1]) dx_q <= add_sum[MAG_W-1:0];
			end
			S_AV: begin
				if (dv_q[MAG_W-1]) dv_q <= add_sum[MAG_W-1:0];
			end
			S_AQ: begin
				p_q   <= {(PROD_W+1-MAG_W)'(0),
					dq_q[MAG_W-1] ? add_sum[MAG_W-1:0] : dq_q};
				cnt_q <= '0;
			end
			S_MUL: begin
				// shift the partial sum and multiplier right together
				p_q <= {1'b0, add_sum[MAG_W:0], p_q[MAG_W-1:1]};
				if (cnt_q == CNT_W'(MAG_W - 1)) begin
					cnt_q <= '0;
					rem_q <= '0;
					quo_q <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			S_DIV: begin
				// one restoring step; the product shifts out from the top
				p_q   <= {p_q[PROD_W-1:0], 1'b0};
				rem_q <= div_ge ? add_sum[MAG_W-1:0] : {rem_q[MAG_W-2:0], p_q[PROD_W-1]};
				quo_q <= (quo_wide > QUOT_CAP) ? QUOT_CAP[QUO_W-1:0] : quo_wide[QUO_W-1:0];
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_SUM: begin
				// saturate to the signed 32-bit range
				if (!add_sum[ADD_W-1] && add_sum[ADD_W-2:DATA_W-1] != '0) begin
					res_q <= {1'b0, {(DATA_W-1){1'b1}}};
				end else if (add_sum[ADD_W-1] && add_sum[ADD_W-2:DATA_W-1] != '1) begin
					res_q <= {1'b1, {(DATA_W-1){1'b0}}};
				end else begin
					res_q <= add_sum[DATA_W-1:0];
				end
				outc_q <= OUT_INTERP;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
